// ===== hw/rtl/dvb_delivery_descriptor_decoder_core_macros.svh =====
// Assertion macros shared by the descriptor decoder RTL.
`ifndef DVB_DELIVERY_DESCRIPTOR_DECODER_CORE_MACROS_SVH
`define DVB_DELIVERY_DESCRIPTOR_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property check, disabled while reset is held.
`define DDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge.
`define DDD_ASSERT_NEVER(label, cond, msg) \
  `DDD_ASSERT(label, !(cond), msg)
`else
`define DDD_ASSERT(label, prop, msg)
`define DDD_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== hw/rtl/ddd_pkg.sv =====
// Types and constants of the DVB delivery descriptor decoder.
package ddd_pkg;

  // Field widths
  localparam int TAG_W       = 8;
  localparam int SIZE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int TAIL_W      = 24;
  localparam int FREQ_W      = 40;
  localparam int SRATE_W     = 30;
  localparam int BCD_W       = 28;
  localparam int SBASE_W     = 24;
  localparam int FMULT_W     = 14;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_TAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAB_TAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TER_TAG = 2'd2;

  // Tag reset values
  localparam logic [TAG_W-1:0] SAT_TAG_RST = 8'd67;
  localparam logic [TAG_W-1:0] CAB_TAG_RST = 8'd68;
  localparam logic [TAG_W-1:0] TER_TAG_RST = 8'd90;

  localparam logic [SIZE_W-1:0] MIN_PAYLOAD = 8'd11;

  // Frequency scale per system and saturation limits
  localparam logic [FMULT_W-1:0] FMULT_SAT  = 14'd10000;
  localparam logic [FMULT_W-1:0] FMULT_CAB  = 14'd100;
  localparam logic [FMULT_W-1:0] FMULT_TER  = 14'd10;
  localparam logic [6:0]         SRATE_MULT = 7'd100;
  localparam logic [FREQ_W-1:0]  FREQ_MAX   = 40'd999999990000;
  localparam logic [SRATE_W-1:0] SRATE_MAX  = 30'd999999900;

  // Delivery system codes
  localparam logic [2:0] SYS_NONE = 3'd0;
  localparam logic [2:0] SYS_S    = 3'd1;
  localparam logic [2:0] SYS_S2   = 3'd2;
  localparam logic [2:0] SYS_C    = 3'd3;
  localparam logic [2:0] SYS_T    = 3'd4;

  // Parameter codes (first member of each run used as a base)
  localparam logic [3:0] FEC_ANY        = 4'd1;
  localparam logic [3:0] FEC_1_2        = 4'd2;
  localparam logic [3:0] FEC_NO_FEC     = 4'd11;
  localparam logic [3:0] MOD_AUTO       = 4'd1;
  localparam logic [3:0] MOD_QPSK       = 4'd2;
  localparam logic [3:0] MOD_8PSK       = 4'd3;
  localparam logic [3:0] MOD_16QAM      = 4'd4;
  localparam logic [3:0] MOD_64QAM      = 4'd6;
  localparam logic [2:0] POL_H          = 3'd1;
  localparam logic [2:0] ROLL_AUTO      = 3'd1;
  localparam logic [2:0] ROLL_035       = 3'd2;
  localparam logic [2:0] BW_AUTO        = 3'd1;
  localparam logic [2:0] BW_8MHZ        = 3'd2;
  localparam logic [2:0] TM_AUTO        = 3'd1;
  localparam logic [2:0] TM_2K          = 3'd2;
  localparam logic [2:0] GI_1_32        = 3'd1;
  localparam logic [2:0] HIER_NONE      = 3'd1;

  // One descriptor as it arrives
  typedef struct packed {
    logic              descriptor_valid;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] payload_size;
    logic [WORD_W-1:0] payload_first_word;
    logic [WORD_W-1:0] payload_second_word;
    logic [TAIL_W-1:0] payload_tail;
  } ddd_item_t;

  // Small coded result fields
  typedef struct packed {
    logic [2:0] polarity;
    logic [3:0] primary_fec;
    logic [2:0] low_priority_fec;
    logic [3:0] modulation;
    logic [2:0] rolloff;
    logic [2:0] bandwidth;
    logic [2:0] tx_mode;
    logic [2:0] guard_int;
    logic [2:0] hierarchy;
  } ddd_codes_t;

  // Decoded descriptor ahead of scaling
  typedef struct packed {
    logic [2:0]         sys;
    logic [WORD_W-1:0]  freq_base;
    logic [FMULT_W-1:0] freq_mult;
    logic [SBASE_W-1:0] srate_base;
    ddd_codes_t         codes;
  } ddd_stage_t;

  // Final result item
  typedef struct packed {
    logic [2:0]         sys_code;
    logic [FREQ_W-1:0]  frequency_hz;
    logic [SRATE_W-1:0] sym_rate;
    ddd_codes_t         codes;
  } ddd_result_t;

endpackage

// ===== hw/rtl/ddd_in_if.sv =====
// Descriptor input channel.
interface ddd_in_if import ddd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              descriptor_valid;
  logic [TAG_W-1:0]  tag;
  logic [SIZE_W-1:0] payload_size;
  logic [WORD_W-1:0] payload_first_word;
  logic [WORD_W-1:0] payload_second_word;
  logic [TAIL_W-1:0] payload_tail;

  modport source (
    output valid, descriptor_valid, tag, payload_size,
           payload_first_word, payload_second_word, payload_tail,
    input  ready
  );
  modport sink (
    input  valid, descriptor_valid, tag, payload_size,
           payload_first_word, payload_second_word, payload_tail,
    output ready
  );
endinterface

// ===== hw/rtl/ddd_out_if.sv =====
// Decoded tuning parameter output channel.
interface ddd_out_if import ddd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         sys_code;
  logic [FREQ_W-1:0]  frequency_hz;
  logic [SRATE_W-1:0] sym_rate;
  logic [2:0]         polarity;
  logic [3:0]         primary_fec;
  logic [2:0]         low_priority_fec;
  logic [3:0]         modulation;
  logic [2:0]         rolloff;
  logic [2:0]         bandwidth;
  logic [2:0]         tx_mode;
  logic [2:0]         guard_int;
  logic [2:0]         hierarchy;

  modport source (
    output valid, sys_code, frequency_hz, sym_rate, polarity,
           primary_fec, low_priority_fec, modulation, rolloff, bandwidth,
           tx_mode, guard_int, hierarchy,
    input  ready
  );
  modport sink (
    input  valid, sys_code, frequency_hz, sym_rate, polarity,
           primary_fec, low_priority_fec, modulation, rolloff, bandwidth,
           tx_mode, guard_int, hierarchy,
    output ready
  );
endinterface

// ===== hw/rtl/ddd_cfg_if.sv =====
// Configuration register write channel.
interface ddd_cfg_if import ddd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TAG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ddd_decode.sv =====
// Descriptor classification, bit slicing and BCD digit sums.
module ddd_decode import ddd_pkg::*; (
  input  ddd_item_t        item,
  input  logic [TAG_W-1:0] sat_tag,
  input  logic [TAG_W-1:0] cab_tag,
  input  logic [TAG_W-1:0] ter_tag,
  output ddd_stage_t       dec
);

  // Decimal weight of each nibble, least significant first
  localparam logic [BCD_W-1:0] BCD_WEIGHT [8] = '{
    28'd1, 28'd10, 28'd100, 28'd1000,
    28'd10000, 28'd100000, 28'd1000000, 28'd10000000
  };

  // Weighted nibble sum; nibbles above 9 are taken at face value
  function automatic logic [BCD_W-1:0] bcd_sum(input logic [WORD_W-1:0] v);
    logic [BCD_W-1:0] acc;
    logic [BCD_W-1:0] nib;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      nib = BCD_W'(v[4*i +: 4]);
      acc = acc + BCD_W'(nib * BCD_WEIGHT[i]);
    end
    return acc;
  endfunction

  function automatic logic [3:0] sat_cab_fec(input logic [3:0] code);
    logic [3:0] res;
    if (code >= 4'd1 && code <= 4'd9) begin
      res = FEC_ANY + code;
    end else if (code == 4'hF) begin
      res = FEC_NO_FEC;
    end else begin
      res = FEC_ANY;
    end
    return res;
  endfunction

  function automatic logic [3:0] ter_fec(input logic [2:0] code);
    return (code <= 3'd4) ? FEC_1_2 + 4'(code) : FEC_ANY;
  endfunction

  logic [7:0]       b4, b5, b6, b7, b10;
  logic             ok, is_sat, is_cab, is_ter;
  logic [BCD_W-1:0] fdig, sdig;
  logic [1:0]       ro;

  assign b4  = item.payload_second_word[31:24];
  assign b5  = item.payload_second_word[23:16];
  assign b6  = item.payload_second_word[15:8];
  assign b7  = item.payload_second_word[7:0];
  assign b10 = item.payload_tail[7:0];
  assign ro  = b6[4:3];

  // Tag match with satellite over cable over terrestrial
  assign ok     = item.descriptor_valid && (item.payload_size >= MIN_PAYLOAD);
  assign is_sat = ok && (item.tag == sat_tag);
  assign is_cab = ok && !is_sat && (item.tag == cab_tag);
  assign is_ter = ok && !is_sat && !is_cab && (item.tag == ter_tag);

  // Frequency is 8 BCD digits, symbol rate 7 of bytes 7..9, 10[7:4]
  assign fdig = bcd_sum(item.payload_first_word);
  assign sdig = bcd_sum({4'h0, b7, item.payload_tail[23:4]});

  always_comb begin
    dec = '0;
    if (is_sat || is_cab) begin
      dec.freq_base         = WORD_W'(fdig);
      dec.freq_mult         = is_sat ? FMULT_SAT : FMULT_CAB;
      dec.srate_base        = sdig[SBASE_W-1:0];
      dec.codes.primary_fec = sat_cab_fec(b10[3:0]);
      if (is_sat) begin
        dec.codes.polarity   = POL_H + 3'(b6[6:5]);
        dec.codes.modulation = MOD_AUTO + 4'(b6[1:0]);
        if (!b6[2]) begin
          dec.sys           = SYS_S;
          dec.codes.rolloff = ROLL_AUTO;
        end else begin
          dec.sys           = SYS_S2;
          dec.codes.rolloff = (ro == 2'd3) ? ROLL_AUTO : ROLL_035 + 3'(ro);
        end
      end else begin
        dec.sys = SYS_C;
        // cable modulation 1..5 maps onto 16QAM..256QAM
        dec.codes.modulation = (b6 >= 8'd1 && b6 <= 8'd5) ?
                               MOD_8PSK + 4'(b6[2:0]) : MOD_AUTO;
      end
    end else if (is_ter) begin
      dec.sys       = SYS_T;
      // all-ones frequency means not given
      dec.freq_base = (&item.payload_first_word) ? '0 : item.payload_first_word;
      dec.freq_mult = FMULT_TER;
      dec.codes.primary_fec      = ter_fec(b5[2:0]);
      dec.codes.low_priority_fec = 3'(ter_fec(b6[7:5]));
      case (b5[7:6])
        2'd0:    dec.codes.modulation = MOD_QPSK;
        2'd1:    dec.codes.modulation = MOD_16QAM;
        2'd2:    dec.codes.modulation = MOD_64QAM;
        default: dec.codes.modulation = MOD_AUTO;
      endcase
      dec.codes.bandwidth = (b4[7:5] <= 3'd3) ? BW_8MHZ + b4[7:5] : BW_AUTO;
      dec.codes.tx_mode   = (b6[2:1] <= 2'd2) ? TM_2K + 3'(b6[2:1]) : TM_AUTO;
      dec.codes.guard_int = GI_1_32 + 3'(b6[4:3]);
      dec.codes.hierarchy = HIER_NONE + 3'(b5[4:3]);
    end
  end

endmodule

// ===== hw/rtl/ddd_scale.sv =====
// Unit scaling and saturation of frequency and symbol rate.
module ddd_scale import ddd_pkg::*; (
  input  ddd_stage_t  dec,
  output ddd_result_t res
);

  localparam int FPROD_W = WORD_W + FMULT_W;
  localparam int SPROD_W = SBASE_W + 7;

  logic [FPROD_W-1:0] freq_prod;
  logic [SPROD_W-1:0] srate_prod;

  // One multiply per quantity
  assign freq_prod  = FPROD_W'(dec.freq_base) * FPROD_W'(dec.freq_mult);
  assign srate_prod = SPROD_W'(dec.srate_base) * SPROD_W'(SRATE_MULT);

  always_comb begin
    res.sys_code     = dec.sys;
    res.frequency_hz = (freq_prod > FPROD_W'(FREQ_MAX)) ?
                       FREQ_MAX : freq_prod[FREQ_W-1:0];
    res.sym_rate     = (srate_prod > SPROD_W'(SRATE_MAX)) ?
                       SRATE_MAX : srate_prod[SRATE_W-1:0];
    res.codes        = dec.codes;
  end

endmodule

// ===== hw/rtl/dvb_delivery_descriptor_decoder_core.sv =====
// Top level of the DVB delivery descriptor decoder.
//
// Decodes one satellite, cable or terrestrial delivery descriptor per clock
// cycle into tuning parameters while the output does not stall. Each item
// passes three registers in order (input, decode, result) and is offered
// on the output from the result register. Bubbles close up under an output
// stall, and input ready drops only once every stage is occupied. The BCD
// digit sums sit in the decode stage and the scaling multiply with
// saturation in the result stage. Tag registers are written through the
// configuration channel, which is always ready; write them only while no
// item is in flight.
`include "dvb_delivery_descriptor_decoder_core_macros.svh"

module dvb_delivery_descriptor_decoder_core import ddd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  ddd_in_if.sink   in_if,
  ddd_out_if.source out_if,
  ddd_cfg_if.sink  cfg_if
);

  // Tag registers
  logic [TAG_W-1:0] sat_tag_r, cab_tag_r, ter_tag_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_tag_r <= SAT_TAG_RST;
      cab_tag_r <= CAB_TAG_RST;
      ter_tag_r <= TER_TAG_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_SAT_TAG: sat_tag_r <= cfg_if.data;
        CFG_CAB_TAG: cab_tag_r <= cfg_if.data;
        CFG_TER_TAG: ter_tag_r <= cfg_if.data;
        default:     ;
      endcase
    end
  end

  // Pipeline handshake
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic s2_ready, s3_ready, adv2, adv3, in_xfer, out_xfer;

  assign s3_ready     = !v3_r || out_if.ready;
  assign adv3         = v2_r && s3_ready;
  assign s2_ready     = !v2_r || s3_ready;
  assign adv2         = v1_r && s2_ready;
  assign in_if.ready  = !v1_r || s2_ready;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign out_xfer     = v3_r && out_if.ready;

  assign v1_nxt = in_xfer ? 1'b1 : (adv2 ? 1'b0 : v1_r);
  assign v2_nxt = adv2    ? 1'b1 : (adv3 ? 1'b0 : v2_r);
  assign v3_nxt = adv3    ? 1'b1 : (out_xfer ? 1'b0 : v3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Stage payloads
  ddd_item_t   item_r, item_nxt;
  ddd_stage_t  dec_r, dec_nxt;
  ddd_result_t res_r, res_nxt;

  always_comb begin
    item_nxt.descriptor_valid    = in_if.descriptor_valid;
    item_nxt.tag                 = in_if.tag;
    item_nxt.payload_size        = in_if.payload_size;
    item_nxt.payload_first_word  = in_if.payload_first_word;
    item_nxt.payload_second_word = in_if.payload_second_word;
    item_nxt.payload_tail        = in_if.payload_tail;
  end

  ddd_decode u_decode (
    .item    (item_r),
    .sat_tag (sat_tag_r),
    .cab_tag (cab_tag_r),
    .ter_tag (ter_tag_r),
    .dec     (dec_nxt)
  );

  ddd_scale u_scale (
    .dec (dec_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_nxt;
    end
    if (adv2) begin
      dec_r <= dec_nxt;
    end
    if (adv3) begin
      res_r <= res_nxt;
    end
  end

  // Result channel
  assign out_if.valid            = v3_r;
  assign out_if.sys_code         = res_r.sys_code;
  assign out_if.frequency_hz     = res_r.frequency_hz;
  assign out_if.sym_rate         = res_r.sym_rate;
  assign out_if.polarity         = res_r.codes.polarity;
  assign out_if.primary_fec      = res_r.codes.primary_fec;
  assign out_if.low_priority_fec = res_r.codes.low_priority_fec;
  assign out_if.modulation       = res_r.codes.modulation;
  assign out_if.rolloff          = res_r.codes.rolloff;
  assign out_if.bandwidth        = res_r.codes.bandwidth;
  assign out_if.tx_mode          = res_r.codes.tx_mode;
  assign out_if.guard_int        = res_r.codes.guard_int;
  assign out_if.hierarchy        = res_r.codes.hierarchy;

  // Checks
  `DDD_ASSERT(a_in_xfer_fills_s1, in_xfer |=> v1_r, "input transfer lost at stage 1")
  `DDD_ASSERT(a_fail_clears,
              (v3_r && res_r.sys_code == SYS_NONE) |->
              (res_r.frequency_hz == '0 && res_r.sym_rate == '0 && res_r.codes == '0),
              "failed decode carries nonzero fields")
  `DDD_ASSERT(a_ter_no_srate,
              (v3_r && res_r.sys_code == SYS_T) |->
              (res_r.sym_rate == '0 && res_r.codes.rolloff == '0),
              "terrestrial result carries satellite fields")
  `DDD_ASSERT_NEVER(a_freq_limit, v3_r && res_r.frequency_hz > FREQ_MAX, "frequency above limit")

endmodule

// ===== dv/tb.sv =====
// Testbench of the DVB delivery descriptor decoder: random and directed descriptors, scoreboard.

// Expected tuning parameters for each accepted descriptor, checked in arrival order.
class tuning_scoreboard;
  // Raw code points of the descriptor fields
  localparam logic [3:0] SC_FEC_LAST      = 4'd9;
  localparam logic [3:0] SC_FEC_NONE      = 4'd15;
  localparam logic [7:0] CAB_MOD_FIRST    = 8'd1;
  localparam logic [7:0] CAB_MOD_LAST     = 8'd5;
  localparam logic [2:0] TER_FEC_LAST     = 3'd4;
  localparam logic [2:0] TER_BW_LAST      = 3'd3;
  localparam logic [1:0] TER_TM_LAST      = 2'd2;
  localparam logic [1:0] TER_CONST_QPSK   = 2'd0;
  localparam logic [1:0] TER_CONST_16QAM  = 2'd1;
  localparam logic [1:0] TER_CONST_64QAM  = 2'd2;
  localparam logic [1:0] SAT_RO_RESERVED  = 2'd3;
  localparam int         MAX_PRINTED      = 100;

  ddd_pkg::ddd_result_t expected_tuning[$];
  logic [7:0] sat_tag;
  logic [7:0] cab_tag;
  logic [7:0] ter_tag;
  int errors;
  int n_checked;
  int sys_count[5];

  function new();
    sat_tag = ddd_pkg::SAT_TAG_RST;
    cab_tag = ddd_pkg::CAB_TAG_RST;
    ter_tag = ddd_pkg::TER_TAG_RST;
    errors = 0;
    n_checked = 0;
    foreach (sys_count[i]) sys_count[i] = 0;
  endfunction

  function void set_tag(logic [ddd_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      ddd_pkg::CFG_SAT_TAG: sat_tag = val;
      ddd_pkg::CFG_CAB_TAG: cab_tag = val;
      ddd_pkg::CFG_TER_TAG: ter_tag = val;
      default: ;
    endcase
  endfunction

  // Weighted decimal sum of nibbles, most significant first, no digit check
  static function longint unsigned bcd_value(logic [31:0] v, int digits);
    longint unsigned acc;
    acc = 0;
    for (int i = 0; i < digits; i++) begin
      acc = acc * 10 + ((v >> (4 * (digits - 1 - i))) & 32'hF);
    end
    return acc;
  endfunction

  static function logic [3:0] sat_cab_fec(logic [3:0] c);
    if (c >= 4'd1 && c <= SC_FEC_LAST) return ddd_pkg::FEC_1_2 + c - 4'd1;
    if (c == SC_FEC_NONE) return ddd_pkg::FEC_NO_FEC;
    return ddd_pkg::FEC_ANY;
  endfunction

  static function logic [3:0] ter_fec(logic [2:0] c);
    return (c <= TER_FEC_LAST) ? ddd_pkg::FEC_1_2 + 4'(c) : ddd_pkg::FEC_ANY;
  endfunction

  function ddd_pkg::ddd_result_t decode_descriptor(ddd_pkg::ddd_item_t d);
    ddd_pkg::ddd_result_t r;
    logic [7:0] b4, b5, b6, b10;
    logic [27:0] srate_digits;
    longint unsigned freq, srate;
    logic [2:0] bw, hier, hp, lp;
    logic [1:0] constel, guard, tm, ro;
    bit is_sat;
    r = '0;
    b4 = d.payload_second_word[31:24];
    b5 = d.payload_second_word[23:16];
    b6 = d.payload_second_word[15:8];
    b10 = d.payload_tail[7:0];
    if (!d.descriptor_valid || d.payload_size < ddd_pkg::MIN_PAYLOAD) return r;

    if (d.tag == sat_tag || d.tag == cab_tag) begin
      // satellite and cable share BCD frequency, symbol rate and FEC layout
      is_sat = (d.tag == sat_tag);
      srate_digits = {d.payload_second_word[7:0], d.payload_tail[23:4]};
      freq = bcd_value(d.payload_first_word, 8) * (is_sat ? 64'd10000 : 64'd100);
      srate = bcd_value({4'h0, srate_digits}, 7) * 64'd100;
      if (freq > ddd_pkg::FREQ_MAX) freq = ddd_pkg::FREQ_MAX;
      if (srate > ddd_pkg::SRATE_MAX) srate = ddd_pkg::SRATE_MAX;
      r.frequency_hz = 40'(freq);
      r.sym_rate = 30'(srate);
      r.codes.primary_fec = sat_cab_fec(b10[3:0]);
      if (is_sat) begin
        r.codes.polarity = ddd_pkg::POL_H + 3'(b6[6:5]);
        r.codes.modulation = ddd_pkg::MOD_AUTO + 4'(b6[1:0]);
        if (!b6[2]) begin
          r.sys_code = ddd_pkg::SYS_S;
          r.codes.rolloff = ddd_pkg::ROLL_AUTO;
        end else begin
          ro = b6[4:3];
          r.sys_code = ddd_pkg::SYS_S2;
          r.codes.rolloff = (ro == SAT_RO_RESERVED) ? ddd_pkg::ROLL_AUTO
                                                    : ddd_pkg::ROLL_035 + 3'(ro);
        end
      end else begin
        r.sys_code = ddd_pkg::SYS_C;
        r.codes.modulation = (b6 >= CAB_MOD_FIRST && b6 <= CAB_MOD_LAST)
                             ? ddd_pkg::MOD_16QAM + b6[3:0] - 4'd1 : ddd_pkg::MOD_AUTO;
      end
    end else if (d.tag == ter_tag) begin
      // terrestrial: binary frequency in 10 Hz units, all-ones means unknown
      bw = b4[7:5];
      constel = b5[7:6];
      hier = b5[5:3];
      hp = b5[2:0];
      lp = b6[7:5];
      guard = b6[4:3];
      tm = b6[2:1];
      r.sys_code = ddd_pkg::SYS_T;
      r.frequency_hz = (d.payload_first_word == '1) ? '0
                       : 40'(d.payload_first_word) * 40'd10;
      r.codes.primary_fec = ter_fec(hp);
      r.codes.low_priority_fec = 3'(ter_fec(lp));
      case (constel)
        TER_CONST_QPSK:  r.codes.modulation = ddd_pkg::MOD_QPSK;
        TER_CONST_16QAM: r.codes.modulation = ddd_pkg::MOD_16QAM;
        TER_CONST_64QAM: r.codes.modulation = ddd_pkg::MOD_64QAM;
        default:         r.codes.modulation = ddd_pkg::MOD_AUTO;
      endcase
      r.codes.bandwidth = (bw <= TER_BW_LAST) ? ddd_pkg::BW_8MHZ + bw : ddd_pkg::BW_AUTO;
      r.codes.tx_mode = (tm <= TER_TM_LAST) ? ddd_pkg::TM_2K + 3'(tm)
                                            : ddd_pkg::TM_AUTO;
      r.codes.guard_int = ddd_pkg::GI_1_32 + 3'(guard);
      r.codes.hierarchy = ddd_pkg::HIER_NONE + 3'(hier[1:0]);
    end
    return r;
  endfunction

  function void note_descriptor(ddd_pkg::ddd_item_t d);
    expected_tuning.push_back(decode_descriptor(d));
  endfunction

  task report(string msg);
    if (errors < MAX_PRINTED) $display("MISMATCH result %0d: %s", n_checked, msg);
    errors++;
  endtask

  task compare_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task check_tuning(ddd_pkg::ddd_result_t got);
    ddd_pkg::ddd_result_t want;
    if (expected_tuning.size() == 0) begin
      report("result transfer with no descriptor pending");
    end else begin
      want = expected_tuning.pop_front();
      compare_field("sys_code", got.sys_code, want.sys_code);
      compare_field("frequency_hz", got.frequency_hz, want.frequency_hz);
      compare_field("sym_rate", got.sym_rate, want.sym_rate);
      compare_field("polarity", got.codes.polarity, want.codes.polarity);
      compare_field("primary_fec", got.codes.primary_fec, want.codes.primary_fec);
      compare_field("low_priority_fec", got.codes.low_priority_fec,
                    want.codes.low_priority_fec);
      compare_field("modulation", got.codes.modulation, want.codes.modulation);
      compare_field("rolloff", got.codes.rolloff, want.codes.rolloff);
      compare_field("bandwidth", got.codes.bandwidth, want.codes.bandwidth);
      compare_field("tx_mode", got.codes.tx_mode, want.codes.tx_mode);
      compare_field("guard_int", got.codes.guard_int, want.codes.guard_int);
      compare_field("hierarchy", got.codes.hierarchy, want.codes.hierarchy);
      if (want.sys_code < 5) sys_count[want.sys_code]++;
    end
    n_checked++;
  endtask
endclass

module tb import ddd_pkg::*; ();
  localparam int CYCLE_LIMIT = 400000;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_PERIODIC, SINK_LONG_STALL
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  ddd_in_if  in_ch ();
  ddd_out_if out_ch ();
  ddd_cfg_if cfg_ch ();

  dvb_delivery_descriptor_decoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  tuning_scoreboard sb;
  int cycle_count = 0;
  int n_sent = 0;
  int n_settings = 1;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  sink_mode_t sink_mode = SINK_OPEN;
  int sink_left = 0;
  int sink_phase = 0;
  bit sink_rdy;

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result side backpressure in randomly chosen modes
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 4));
      sink_left = $urandom_range(40, 160);
    end else begin
      sink_left = sink_left - 1;
    end
    sink_phase = sink_phase + 1;
    case (sink_mode)
      SINK_OPEN:     sink_rdy = 1'b1;
      SINK_MOSTLY:   sink_rdy = ($urandom_range(0, 9) < 7);
      SINK_SPARSE:   sink_rdy = ($urandom_range(0, 9) < 3);
      SINK_PERIODIC: sink_rdy = (sink_phase % 4) != 0;
      default:       sink_rdy = (sink_phase % 20) >= 14;
    endcase
    out_ch.ready <= sink_rdy;
  end

  // Result monitor
  always @(posedge clk) begin
    ddd_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.sys_code = out_ch.sys_code;
      got.frequency_hz = out_ch.frequency_hz;
      got.sym_rate = out_ch.sym_rate;
      got.codes.polarity = out_ch.polarity;
      got.codes.primary_fec = out_ch.primary_fec;
      got.codes.low_priority_fec = out_ch.low_priority_fec;
      got.codes.modulation = out_ch.modulation;
      got.codes.rolloff = out_ch.rolloff;
      got.codes.bandwidth = out_ch.bandwidth;
      got.codes.tx_mode = out_ch.tx_mode;
      got.codes.guard_int = out_ch.guard_int;
      got.codes.hierarchy = out_ch.hierarchy;
      sb.check_tuning(got);
    end
  end

  function automatic ddd_item_t desc(logic v, logic [7:0] tag, logic [7:0] size,
                                     logic [31:0] w0, logic [31:0] w1, logic [23:0] w2);
    ddd_item_t d;
    d.descriptor_valid = v;
    d.tag = tag;
    d.payload_size = size;
    d.payload_first_word = w0;
    d.payload_second_word = w1;
    d.payload_tail = w2;
    return d;
  endfunction

  function automatic logic [31:0] random_bcd(int digits);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < digits; i++) v = (v << 4) | 32'($urandom_range(0, 9));
    return v;
  endfunction

  // Mostly well-formed descriptors for the current tags, some noise
  function automatic ddd_item_t random_descriptor();
    ddd_item_t d;
    int sel;
    int pick;
    logic [31:0] sdig;
    sel = $urandom_range(0, 9);
    d.descriptor_valid = ($urandom_range(0, 19) != 0);
    if (sel < 3) d.tag = sb.sat_tag;
    else if (sel < 5) d.tag = sb.cab_tag;
    else if (sel < 8) d.tag = sb.ter_tag;
    else d.tag = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick == 0) d.payload_size = 8'($urandom_range(0, 255));
    else if (pick == 1) d.payload_size = 8'($urandom_range(0, 11));
    else d.payload_size = 8'($urandom_range(11, 255));
    pick = $urandom_range(0, 9);
    if (pick < 5) d.payload_first_word = random_bcd(8);
    else if (pick < 9) d.payload_first_word = $urandom;
    else d.payload_first_word = '1;
    d.payload_second_word = $urandom;
    d.payload_tail = 24'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      sdig = random_bcd(7);
      d.payload_second_word[7:0] = sdig[27:20];
      d.payload_tail[23:4] = sdig[19:0];
    end
    return d;
  endfunction

  // One descriptor transfer, with sender bursts and gaps
  task automatic send_descriptor(ddd_item_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.descriptor_valid <= d.descriptor_valid;
    in_ch.tag <= d.tag;
    in_ch.payload_size <= d.payload_size;
    in_ch.payload_first_word <= d.payload_first_word;
    in_ch.payload_second_word <= d.payload_second_word;
    in_ch.payload_tail <= d.payload_tail;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_descriptor(d);
    n_sent++;
  endtask

  // Stop sending and wait until every result has been checked
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_tuning.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tag(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_tag(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_tags(logic [7:0] sat, logic [7:0] cab, logic [7:0] ter);
    write_tag(CFG_SAT_TAG, sat);
    write_tag(CFG_CAB_TAG, cab);
    write_tag(CFG_TER_TAG, ter);
    n_settings++;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_descriptor(random_descriptor());
  endtask

  // Hand-picked descriptors under the reset tags
  task automatic run_directed();
    // DVB-S, 11.75 GHz, vertical, QPSK, 27.5 Msym/s, FEC 3/4
    send_descriptor(desc(1'b1, 8'd67, 8'd11, 32'h01175000, 32'h00002102, 24'h750003));
    // DVB-S2 through every roll-off code, all polarities
    send_descriptor(desc(1'b1, 8'd67, 8'd12, 32'h01234567, 32'h00000601, 24'h23456A));
    send_descriptor(desc(1'b1, 8'd67, 8'd20, 32'h00987654, 32'h00002E00, 24'h999990));
    send_descriptor(desc(1'b1, 8'd67, 8'd40, 32'h09999999, 32'h00005609, 24'h000009));
    send_descriptor(desc(1'b1, 8'd67, 8'd99, 32'h00000001, 32'h00007F00, 24'h00000B));
    // saturation of both BCD sums with FEC none, then all-zero fields
    send_descriptor(desc(1'b1, 8'd67, 8'd11, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF));
    send_descriptor(desc(1'b1, 8'd67, 8'd255, 32'h00000000, 32'h00000000, 24'h000000));
    // failures: flag low, short payload, unknown tags
    send_descriptor(desc(1'b0, 8'd67, 8'd11, 32'h01175000, 32'h00002102, 24'h750003));
    send_descriptor(desc(1'b1, 8'd67, 8'd10, 32'h01175000, 32'h00002102, 24'h750003));
    send_descriptor(desc(1'b1, 8'd68, 8'd0, 32'h03460000, 32'h00000300, 24'h690005));
    send_descriptor(desc(1'b1, 8'd0, 8'd11, 32'h01175000, 32'h00002102, 24'h750003));
    send_descriptor(desc(1'b1, 8'd255, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF));
    // DVB-C 346 MHz, 64QAM, 6.9 Msym/s, FEC 7/8; then edge modulation codes
    send_descriptor(desc(1'b1, 8'd68, 8'd11, 32'h03460000, 32'h00000300, 24'h690005));
    send_descriptor(desc(1'b1, 8'd68, 8'd11, 32'h00000000, 32'h00000000, 24'h000000));
    send_descriptor(desc(1'b1, 8'd68, 8'd11, 32'h12345678, 32'hFFFF0512, 24'h345670));
    send_descriptor(desc(1'b1, 8'd68, 8'd11, 32'hFFFFFFFF, 32'h0000FFFF, 24'hFFFFFF));
    send_descriptor(desc(1'b1, 8'd68, 8'd11, 32'h00000001, 32'h00000100, 24'h00000F));
    // DVB-T 474 MHz, then all-ones frequency, all-zero, reserved codes
    send_descriptor(desc(1'b1, 8'd90, 8'd11, 32'd47400000, 32'h1F423200, 24'h000000));
    send_descriptor(desc(1'b1, 8'd90, 8'd11, 32'hFFFFFFFF, 32'hE0FFFFFF, 24'hFFFFFF));
    send_descriptor(desc(1'b1, 8'd90, 8'd11, 32'h00000000, 32'h00000000, 24'h000000));
    send_descriptor(desc(1'b1, 8'd90, 8'd11, 32'hFFFFFFFE, 32'h60A4AC00, 24'h123456));
    send_descriptor(desc(1'b1, 8'd90, 8'd11, 32'h80000000, 32'h809B5400, 24'h000000));
  endtask

  // Main sequence
  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.descriptor_valid <= 1'b0;
    in_ch.tag <= '0;
    in_ch.payload_size <= '0;
    in_ch.payload_first_word <= '0;
    in_ch.payload_second_word <= '0;
    in_ch.payload_tail <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_SAT_TAG;
    cfg_ch.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset tags
    run_directed();
    run_random(250);
    drain();

    // arbitrary tags
    apply_tags(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    run_random(250);
    drain();

    // all three tags equal at zero: satellite must win
    apply_tags(8'd0, 8'd0, 8'd0);
    run_random(150);
    drain();

    // cable and terrestrial overlap at the top of the range
    apply_tags(8'd1, 8'd255, 8'd255);
    run_random(150);
    drain();

    // extremes spread apart, sender never idles
    no_gaps = 1'b1;
    apply_tags(8'd255, 8'd0, 8'd128);
    run_random(180);
    drain();

    $display("checked %0d results from %0d descriptors under %0d tag settings",
             sb.n_checked, n_sent, n_settings);
    $display("by system: failed %0d, DVB-S %0d, DVB-S2 %0d, DVB-C %0d, DVB-T %0d",
             sb.sys_count[SYS_NONE], sb.sys_count[SYS_S], sb.sys_count[SYS_S2],
             sb.sys_count[SYS_C], sb.sys_count[SYS_T]);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== dvb_delivery_descriptor_decoder_core.f =====
+incdir+hw/rtl
hw/rtl/ddd_pkg.sv
hw/rtl/ddd_in_if.sv
hw/rtl/ddd_out_if.sv
hw/rtl/ddd_cfg_if.sv
hw/rtl/ddd_decode.sv
hw/rtl/ddd_scale.sv
hw/rtl/dvb_delivery_descriptor_decoder_core.sv
dv/tb.sv
